### hw/rtl/nta_pkg.sv
package nta_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_REFRESHED  = 3'd0,
    STATUS_ADDED      = 3'd1,
    STATUS_DROPPED    = 3'd2,
    STATUS_TICK_KEEP  = 3'd3,
    STATUS_TICK_DROP  = 3'd4
  } status_e;

  // Input action codes.
  typedef enum logic {
    ACTION_HELLO = 1'b0,
    ACTION_TICK  = 1'b1
  } action_e;

  // Field widths fixed by the word formats.
  localparam int unsigned IFACE_W  = 2;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned AGE_W    = 10;
  localparam int unsigned INTV_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [AGE_W-1:0] AGE_MAX       = '1;
  localparam logic [INTV_W-1:0] INTERVAL_RST = 8'd5;

endpackage

### hw/rtl/nta_in_if.sv
interface nta_in_if;
  import nta_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [IFACE_W-1:0]  iface_index;
  logic [ID_W-1:0]     neighbor_id;
  logic [ID_W-1:0]     neighbor_addr;
  logic [ID_W-1:0]     neighbor_mask;

  modport source (
    output valid, action, iface_index, neighbor_id, neighbor_addr, neighbor_mask,
    input  ready
  );

  modport sink (
    input  valid, action, iface_index, neighbor_id, neighbor_addr, neighbor_mask,
    output ready
  );
endinterface

### hw/rtl/nta_out_if.sv
interface nta_out_if;
  import nta_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                lsu_request;
  logic [COUNT_W-1:0]  removed_count;
  logic [COUNT_W-1:0]  neighbor_total;

  modport source (
    output valid, status, lsu_request, removed_count, neighbor_total,
    input  ready
  );

  modport sink (
    input  valid, status, lsu_request, removed_count, neighbor_total,
    output ready
  );
endinterface

### hw/rtl/neighbor_table_with_aging.sv
// Channel   Direction  Contents
// in_i      sink       action, iface_index, neighbor_id, neighbor_addr, neighbor_mask
// out_o     source     status, lsu_request, removed_count, neighbor_total
// cfg       write      cfg_we_i, cfg_wdata_i (hello_interval)
//
// A word is accepted, then the table is walked one entry per cycle through a single compare
// and age-update unit, and the result is then committed; a hello on an interface out of range
// skips the walk and goes straight to the commit. The next word is taken in the cycle after.
// Reset clears the valid bits, the count and hello_interval (back to 5) at once.
// in_i.ready is high only while the sequencer is idle; a result waits in the output
// register, and the commit step holds while that register is still occupied.
module neighbor_table_with_aging #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned IFACE_COUNT   = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  nta_in_if.sink                    in_i,
  nta_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [nta_pkg::INTV_W-1:0] cfg_wdata_i
);
  import nta_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e               state_q;
  logic [INTV_W-1:0]    interval_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 item_tick_q;
  logic                 item_bad_q;
  logic [IFACE_W-1:0]   item_iface_q;
  logic [ID_W-1:0]      item_id_q;
  logic                 found_q;
  logic [IDX_W-1:0]     found_idx_q;
  logic                 free_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [CNT_W-1:0]     removed_q;
  logic [CNT_W-1:0]     total_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  // Entry storage. Address and mask of a hello are never read back, so they
  // are not kept.
  logic [IFACE_W-1:0]   ent_iface_q [TABLE_ENTRIES];
  logic [ID_W-1:0]      ent_id_q    [TABLE_ENTRIES];
  logic [AGE_W-1:0]     ent_age_q   [TABLE_ENTRIES];

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic                 out_lsu_q;
  logic [COUNT_W-1:0]   out_removed_q;
  logic [COUNT_W-1:0]   out_total_q;

  logic                 in_fire;
  logic                 in_bad;
  logic [AGE_W-1:0]     dead_time;
  logic                 cur_valid;
  logic [AGE_W-1:0]     cur_age;
  logic                 cur_match;
  logic                 cur_expired;
  logic                 out_free;
  logic                 commit;
  logic                 age_we;
  logic [IDX_W-1:0]     age_waddr;
  logic [AGE_W-1:0]     age_wdata;
  logic                 ent_we;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_bad     = ({3'b000, in_i.iface_index} >= 5'(IFACE_COUNT));

  // Dead time is three hello intervals: one shift and one add.
  assign dead_time = {1'b0, interval_q, 1'b0} + {2'b00, interval_q};

  // Shared per-entry unit: looks at the entry under the scan index.
  assign cur_valid   = valid_q[idx_q];
  assign cur_age     = ent_age_q[idx_q];
  assign cur_match   = cur_valid && (ent_iface_q[idx_q] == item_iface_q)
                       && (ent_id_q[idx_q] == item_id_q);
  assign cur_expired = cur_valid && (cur_age > dead_time);

  assign out_free = !out_valid_q || out_o.ready;
  assign commit   = (state_q == ST_COMMIT) && out_free;

  // Age write port: the tick scan bumps the current entry, a hello commit clears one.
  always_comb begin
    age_we    = 1'b0;
    age_waddr = idx_q;
    age_wdata = cur_age + AGE_W'(1);
    ent_we    = 1'b0;
    if (state_q == ST_SCAN && item_tick_q) begin
      age_we = cur_valid && !cur_expired && (cur_age != AGE_MAX);
    end else if (commit && !item_tick_q && !item_bad_q) begin
      age_wdata = '0;
      if (found_q) begin
        age_we    = 1'b1;
        age_waddr = found_idx_q;
      end else if (free_q) begin
        age_we    = 1'b1;
        age_waddr = free_idx_q;
        ent_we    = 1'b1;
      end
    end
  end

  // Entry storage writes.
  always_ff @(posedge clk_i) begin
    if (age_we) begin
      ent_age_q[age_waddr] <= age_wdata;
    end
    if (ent_we) begin
      ent_iface_q[free_idx_q] <= item_iface_q;
      ent_id_q[free_idx_q]    <= item_id_q;
    end
  end

  // Sequencer, table control state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      interval_q    <= INTERVAL_RST;
      idx_q         <= '0;
      item_tick_q   <= 1'b0;
      item_bad_q    <= 1'b0;
      item_iface_q  <= '0;
      item_id_q     <= '0;
      found_q       <= 1'b0;
      found_idx_q   <= '0;
      free_q        <= 1'b0;
      free_idx_q    <= '0;
      removed_q     <= '0;
      total_q       <= '0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= '0;
      out_lsu_q     <= 1'b0;
      out_removed_q <= '0;
      out_total_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready && !commit) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            item_tick_q  <= (in_i.action == ACTION_TICK);
            item_bad_q   <= (in_i.action == ACTION_HELLO) && in_bad;
            item_iface_q <= in_i.iface_index;
            item_id_q    <= in_i.neighbor_id;
            idx_q        <= '0;
            found_q      <= 1'b0;
            free_q       <= 1'b0;
            removed_q    <= '0;
            if (in_i.action == ACTION_HELLO && in_bad) begin
              state_q <= ST_COMMIT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (item_tick_q) begin
            // Remove an expired entry; its age is bumped by the write port otherwise.
            if (cur_expired) begin
              valid_q[idx_q] <= 1'b0;
              removed_q      <= removed_q + CNT_W'(1);
              total_q        <= total_q - CNT_W'(1);
            end
          end else begin
            // Remember the first match and the lowest free entry.
            if (cur_match && !found_q) begin
              found_q     <= 1'b1;
              found_idx_q <= idx_q;
            end
            if (!cur_valid && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= idx_q;
            end
          end
          if (idx_q == IDX_LAST) begin
            state_q <= ST_COMMIT;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        ST_COMMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_removed_q <= COUNT_W'(removed_q);
            if (item_tick_q) begin
              out_total_q <= COUNT_W'(total_q);
              if (removed_q != '0) begin
                out_status_q <= STATUS_TICK_DROP;
                out_lsu_q    <= 1'b1;
              end else begin
                out_status_q <= STATUS_TICK_KEEP;
                out_lsu_q    <= 1'b0;
              end
            end else if (item_bad_q) begin
              out_total_q  <= COUNT_W'(total_q);
              out_status_q <= STATUS_DROPPED;
              out_lsu_q    <= 1'b0;
            end else if (found_q) begin
              out_total_q  <= COUNT_W'(total_q);
              out_status_q <= STATUS_REFRESHED;
              out_lsu_q    <= 1'b0;
            end else if (free_q) begin
              valid_q[free_idx_q] <= 1'b1;
              total_q             <= total_q + CNT_W'(1);
              out_total_q         <= COUNT_W'(total_q + CNT_W'(1));
              out_status_q        <= STATUS_ADDED;
              out_lsu_q           <= 1'b1;
            end else begin
              out_total_q  <= COUNT_W'(total_q);
              out_status_q <= STATUS_DROPPED;
              out_lsu_q    <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.lsu_request    = out_lsu_q;
  assign out_o.removed_count  = out_removed_q;
  assign out_o.neighbor_total = out_total_q;

endmodule

### tb/nta_table_monitor.sv
module nta_table_monitor
  import nta_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned IFACE_COUNT   = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nta_in_if                 in_i,
  nta_out_if                out_i,
  input  logic              cfg_we_i,
  input  logic [INTV_W-1:0] cfg_wdata_i,
  output int unsigned       pending_o,
  output int unsigned       failures_o,
  output int unsigned       added_o,
  output int unsigned       refreshed_o,
  output int unsigned       dropped_o,
  output int unsigned       purged_o
);

  // An entry is declared dead once its age passes this many hello periods.
  localparam int unsigned DEAD_FACTOR = 3;
  // Only the first mismatches are printed; all of them are counted.
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    status_e            status;
    logic               lsu_request;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] neighbor_total;
  } table_outcome_t;

  // Shadow copy of the neighbor table and the hello period.
  logic                entry_live [TABLE_ENTRIES];
  logic [IFACE_W-1:0]  entry_port [TABLE_ENTRIES];
  logic [ID_W-1:0]     entry_rid  [TABLE_ENTRIES];
  logic [ID_W-1:0]     entry_addr [TABLE_ENTRIES];
  logic [ID_W-1:0]     entry_mask [TABLE_ENTRIES];
  logic [AGE_W-1:0]    entry_age  [TABLE_ENTRIES];
  logic [INTV_W-1:0]   hello_interval;

  // Outcomes of accepted words, oldest first.
  table_outcome_t pending_outcomes [$];

  // Applies one word to the shadow table and returns the outcome it must produce.
  function automatic table_outcome_t apply_word(logic act, logic [IFACE_W-1:0] port,
                                                logic [ID_W-1:0] rid, logic [ID_W-1:0] addr,
                                                logic [ID_W-1:0] mask);
    table_outcome_t res;
    int             dead_time;
    int             hit;
    int             slot;
    int unsigned    gone;
    int unsigned    live;
    res  = '0;
    gone = 0;
    live = 0;
    if (act == ACTION_TICK) begin
      // Age every live entry; the ones past the dead time are removed.
      dead_time = DEAD_FACTOR * int'(hello_interval);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (entry_live[i]) begin
          if (int'(entry_age[i]) > dead_time) begin
            entry_live[i] = 1'b0;
            gone++;
          end else if (entry_age[i] != AGE_MAX) begin
            entry_age[i] = entry_age[i] + 1'b1;
          end
        end
      end
      if (gone != 0) begin
        res.status      = STATUS_TICK_DROP;
        res.lsu_request = 1'b1;
      end else begin
        res.status = STATUS_TICK_KEEP;
      end
    end else if (port >= IFACE_COUNT) begin
      res.status = STATUS_DROPPED;
    end else begin
      // Look for the router on this interface and for the lowest free entry.
      hit  = -1;
      slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (entry_live[i]) begin
          if (hit < 0 && entry_port[i] == port && entry_rid[i] == rid) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (hit >= 0) begin
        entry_age[hit] = '0;
        res.status     = STATUS_REFRESHED;
      end else if (slot >= 0) begin
        entry_live[slot] = 1'b1;
        entry_port[slot] = port;
        entry_rid[slot]  = rid;
        entry_addr[slot] = addr;
        entry_mask[slot] = mask;
        entry_age[slot]  = '0;
        res.status       = STATUS_ADDED;
        res.lsu_request  = 1'b1;
      end else begin
        res.status = STATUS_DROPPED;
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (entry_live[i]) live++;
    end
    res.removed_count  = COUNT_W'(gone);
    res.neighbor_total = COUNT_W'(live);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (failures_o < PRINT_LIMIT) begin
      $display("Mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    end
    failures_o++;
  endtask

  // Compares the word leaving the block with the oldest outstanding outcome.
  task automatic compare_outcome();
    table_outcome_t want;
    if (pending_outcomes.size() == 0) begin
      report_mismatch("status of a word nobody asked for", out_i.status, 0);
    end else begin
      want = pending_outcomes.pop_front();
      if (out_i.status !== want.status) report_mismatch("status", out_i.status, want.status);
      if (out_i.lsu_request !== want.lsu_request) begin
        report_mismatch("lsu_request", out_i.lsu_request, want.lsu_request);
      end
      if (out_i.removed_count !== want.removed_count) begin
        report_mismatch("removed_count", out_i.removed_count, want.removed_count);
      end
      if (out_i.neighbor_total !== want.neighbor_total) begin
        report_mismatch("neighbor_total", out_i.neighbor_total, want.neighbor_total);
      end
    end
  endtask

  // Follow the register, both channels and the tallies at every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    table_outcome_t res;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) entry_live[i] = 1'b0;
      hello_interval = INTERVAL_RST;
      pending_outcomes.delete();
      pending_o   <= 0;
      failures_o  = 0;
      added_o     <= 0;
      refreshed_o <= 0;
      dropped_o   <= 0;
      purged_o    <= 0;
    end else begin
      if (cfg_we_i) hello_interval = cfg_wdata_i;
      if (in_i.valid && in_i.ready) begin
        res = apply_word(in_i.action, in_i.iface_index, in_i.neighbor_id,
                         in_i.neighbor_addr, in_i.neighbor_mask);
        pending_outcomes.push_back(res);
        case (res.status)
          STATUS_ADDED:     added_o <= added_o + 1;
          STATUS_REFRESHED: refreshed_o <= refreshed_o + 1;
          STATUS_DROPPED:   dropped_o <= dropped_o + 1;
          default:          purged_o <= purged_o + res.removed_count;
        endcase
      end
      if (out_i.valid && out_i.ready) compare_outcome();
      pending_o <= pending_outcomes.size();
    end
  end

endmodule

### tb/testbench.sv
module testbench;
  import nta_pkg::*;

  localparam int unsigned TABLE_ENTRIES   = 16;
  localparam int unsigned IFACE_COUNT     = 4;
  localparam int unsigned PHASE_COUNT     = 8;
  localparam int unsigned PHASE_WORDS     = 176;
  localparam int unsigned POOL_SIZE       = 20;
  localparam int unsigned PRESSURE_PHASE  = 2;
  localparam int unsigned PRESSURE_CYCLES = 300;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned SETTLE_CYCLES   = TABLE_ENTRIES + 8;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [INTV_W-1:0] cfg_wdata;

  nta_in_if  in_ch ();
  nta_out_if out_ch ();

  int unsigned pending;
  int unsigned failures;
  int unsigned added;
  int unsigned refreshed;
  int unsigned dropped;
  int unsigned purged;
  int unsigned words_sent = 0;
  int unsigned phase_no = 0;
  int unsigned idle_cycles = 0;
  logic        steady = 1'b0;

  // Router ids that keep coming back, so that hellos refresh as well as add.
  logic [ID_W-1:0]    pool_id   [POOL_SIZE];
  logic [IFACE_W-1:0] pool_port [POOL_SIZE];

  // Hello period per random phase, the extremes among them.
  logic [INTV_W-1:0] phase_interval [PHASE_COUNT] =
    '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd7, 8'd1, 8'd5};

  neighbor_table_with_aging #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IFACE_COUNT  (IFACE_COUNT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  nta_table_monitor #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IFACE_COUNT  (IFACE_COUNT)
  ) table_watch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_i      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (pending),
    .failures_o (failures),
    .added_o    (added),
    .refreshed_o(refreshed),
    .dropped_o  (dropped),
    .purged_o   (purged)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one word and returns once it has been accepted, then maybe pauses.
  task automatic send_word(action_e act, logic [IFACE_W-1:0] port, logic [ID_W-1:0] rid,
                           logic [ID_W-1:0] addr, logic [ID_W-1:0] mask);
    int unsigned gap;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.iface_index   <= port;
    in_ch.neighbor_id   <= rid;
    in_ch.neighbor_addr <= addr;
    in_ch.neighbor_mask <= mask;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
    gap = steady ? 0 : pause_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mix of ticks, known routers, known ids on another interface and strangers.
  task automatic send_random_word();
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, POOL_SIZE - 1);
    if (roll < 25) begin
      send_word(ACTION_TICK, IFACE_W'($urandom), $urandom, $urandom, $urandom);
    end else if (roll < 70) begin
      send_word(ACTION_HELLO, pool_port[pick], pool_id[pick], $urandom, $urandom);
    end else if (roll < 82) begin
      send_word(ACTION_HELLO, pool_port[pick] + IFACE_W'($urandom_range(1, 3)), pool_id[pick],
                $urandom, $urandom);
    end else begin
      send_word(ACTION_HELLO, IFACE_W'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  // Waits until every accepted word has come back.
  task automatic drain_table();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [INTV_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off that backs up the block.
  initial begin
    bit          pressure_done;
    int unsigned stall;
    pressure_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!pressure_done && phase_no == PRESSURE_PHASE) begin
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk_i);
        pressure_done = 1'b1;
      end else begin
        stall = steady ? 0 : pause_len();
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Ends the run when nothing has moved on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed words, then random phases at different hello periods.
  initial begin
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACTION_HELLO;
    in_ch.iface_index   <= '0;
    in_ch.neighbor_id   <= '0;
    in_ch.neighbor_addr <= '0;
    in_ch.neighbor_mask <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All-zero and all-one routers, a refresh that keeps the old address,
    // and the same id heard on a second interface.
    send_word(ACTION_HELLO, 2'd0, '0, '0, '0);
    send_word(ACTION_HELLO, 2'd3, '1, '1, '1);
    send_word(ACTION_HELLO, 2'd0, '0, 32'h0A00_0001, 32'hFFFF_FF00);
    send_word(ACTION_HELLO, 2'd1, '0, 32'hC0A8_0101, 32'hFFFF_0000);
    send_word(ACTION_TICK, 2'd3, '1, '1, '1);

    // Fill the table, then a stranger is dropped and a known router still refreshes.
    for (int k = 0; k < TABLE_ENTRIES - 3; k++) begin
      send_word(ACTION_HELLO, IFACE_W'(k), 32'h0A00_0010 + k, $urandom, $urandom);
    end
    send_word(ACTION_HELLO, 2'd2, 32'hDEAD_BEEF, $urandom, $urandom);
    send_word(ACTION_HELLO, 2'd3, '1, '0, '0);
    send_word(ACTION_TICK, 2'd0, '0, '0, '0);
    send_word(ACTION_HELLO, 2'd0, '0, '0, '0);

    // A zero period: the first tick removes everything but the fresh entry,
    // the second tick removes that one too.
    drain_table();
    write_interval(8'd0);
    send_word(ACTION_TICK, 2'd1, $urandom, $urandom, $urandom);
    send_word(ACTION_TICK, 2'd2, $urandom, $urandom, $urandom);

    for (int p = 1; p <= PHASE_COUNT; p++) begin
      drain_table();
      write_interval(phase_interval[p - 1]);
      for (int k = 0; k < POOL_SIZE; k++) begin
        pool_id[k]   = $urandom;
        pool_port[k] = IFACE_W'($urandom);
      end
      steady   = (p == 4 || p == 7);
      phase_no = p;
      repeat (PHASE_WORDS) send_random_word();
    end

    drain_table();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d hellos and ticks over %0d hello periods from 0 to 255,", words_sent,
             PHASE_COUNT + 2);
    $display("with %0d adds, %0d refreshes, %0d drops and %0d entries aged out.", added,
             refreshed, dropped, purged);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/nta_pkg.sv
hw/rtl/nta_in_if.sv
hw/rtl/nta_out_if.sv
hw/rtl/neighbor_table_with_aging.sv
tb/nta_table_monitor.sv
tb/testbench.sv
